// ----- hdl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define CHK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked on every rising edge outside reset
`define CHK_IMPLY(label, cond, prop, msg) \
  `CHK_ASSERT(label, (cond) |-> (prop), msg)

`endif

// ----- hdl/bmp2lcd_pkg.sv -----
`timescale 1ns / 1ps

package bmp2lcd_pkg;

  localparam int IMAGE_WIDTH  = 128;
  localparam int IMAGE_HEIGHT = 64;
  // stored rows are padded to whole 32-bit words
  localparam int ROW_BYTES    = ((IMAGE_WIDTH + 31) / 32) * 4;

  localparam int STORE_DEPTH  = 1024;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int OFFSET_W     = 10;
  localparam int PIXEL_W      = 8;
  localparam int PAGE_W       = 3;
  localparam int COL_W        = 7;
  localparam int STEP_W       = 3;
  localparam int ROWS_PER_PAGE = 1 << STEP_W;
  localparam int DROW_W       = PAGE_W + STEP_W;
  localparam int SROW_W       = $clog2(IMAGE_HEIGHT);
  localparam int BYTE_COL_W   = COL_W - 3;
  localparam int FULL_ADDR_W  = $clog2(IMAGE_HEIGHT * ROW_BYTES + (1 << BYTE_COL_W));

  localparam int IN_TDATA_W   = 32;
  localparam int OUT_TDATA_W  = 8;

  // tdata field positions, lowest bit first
  localparam int OFFSET_LSB   = 0;
  localparam int PIXEL_LSB    = OFFSET_LSB + OFFSET_W;
  localparam int PAGE_LSB     = PIXEL_LSB + PIXEL_W;
  localparam int COL_LSB      = PAGE_LSB + PAGE_W;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_READ = 1'b1
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GATHER,
    ST_FINISH
  } seq_state_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

endpackage

// ----- hdl/bitmap_to_lcd_page_converter_top.sv -----
`timescale 1ns / 1ps
// load request: the byte is written at the edge that takes it; loads can run every cycle while no read holds the input
// read request: eight store reads through one port in the gather state, result registered out of the finish state
// a read keeps the block busy through its gather and finish states; the next request is taken once it is back in idle
// the result waits in an output register, the following read stalls in its finish state only while it is not taken
// rst clears control state only; the frame store is not cleared and holds junk until loaded
module bitmap_to_lcd_page_converter_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // load_offset[9:0], pixel_byte[17:10], page_index[20:18], column_index[27:21], zero[31:28]
  input  logic [bmp2lcd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // req_type[0]
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // page_byte[7:0]
  output logic [bmp2lcd_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  bmp2lcd_pkg::req_kind_t              kind;
  bmp2lcd_pkg::rd_req_t                rd;
  logic [bmp2lcd_pkg::PIXEL_W-1:0]     rd_data;
  logic                                store_we;

  assign kind     = bmp2lcd_pkg::req_kind_t'(s_axis_tuser);
  assign store_we = s_axis_tvalid && s_axis_tready && (kind == bmp2lcd_pkg::REQ_LOAD);

  bmp2lcd_ram #(
    .WIDTH (bmp2lcd_pkg::PIXEL_W),
    .DEPTH (bmp2lcd_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (s_axis_tdata[bmp2lcd_pkg::OFFSET_LSB +: bmp2lcd_pkg::ADDR_W]),
    .wdata (s_axis_tdata[bmp2lcd_pkg::PIXEL_LSB +: bmp2lcd_pkg::PIXEL_W]),
    .re    (rd.en),
    .raddr (rd.addr),
    .rdata (rd_data)
  );

  bmp2lcd_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_kind   (kind),
    .in_page   (s_axis_tdata[bmp2lcd_pkg::PAGE_LSB +: bmp2lcd_pkg::PAGE_W]),
    .in_column (s_axis_tdata[bmp2lcd_pkg::COL_LSB +: bmp2lcd_pkg::COL_W]),
    .rd        (rd),
    .rd_data   (rd_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata)
  );

endmodule

// ----- hdl/bmp2lcd_ram.sv -----
`timescale 1ns / 1ps

module bmp2lcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/bmp2lcd_seq.sv -----
`timescale 1ns / 1ps

module bmp2lcd_seq (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  bmp2lcd_pkg::req_kind_t              in_kind,
  input  logic [bmp2lcd_pkg::PAGE_W-1:0]      in_page,
  input  logic [bmp2lcd_pkg::COL_W-1:0]       in_column,
  output bmp2lcd_pkg::rd_req_t                rd,
  input  logic [bmp2lcd_pkg::PIXEL_W-1:0]     rd_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bmp2lcd_pkg::OUT_TDATA_W-1:0] out_byte
);

  bmp2lcd_pkg::seq_state_t state, state_next;

  logic [bmp2lcd_pkg::STEP_W-1:0]      step;
  logic [bmp2lcd_pkg::PAGE_W-1:0]      page;
  logic [bmp2lcd_pkg::COL_W-1:0]       column;
  logic [bmp2lcd_pkg::OUT_TDATA_W-1:0] acc;
  logic [bmp2lcd_pkg::STEP_W-1:0]      issued_x;
  logic                                issued_ok;
  logic                                issued_valid;

  logic [bmp2lcd_pkg::DROW_W-1:0]      drow;
  logic [bmp2lcd_pkg::SROW_W-1:0]      srow;
  logic [bmp2lcd_pkg::FULL_ADDR_W-1:0] addr_full;
  logic                                pix_ok;
  logic                                pix;
  logic [bmp2lcd_pkg::OUT_TDATA_W-1:0] acc_now;
  logic                                accept_read;
  logic                                slot_free;
  logic                                last_step;

  assign accept_read = in_valid && in_ready && (in_kind == bmp2lcd_pkg::REQ_READ);
  assign slot_free   = !out_valid || out_ready;
  assign last_step   = (step == bmp2lcd_pkg::STEP_W'(bmp2lcd_pkg::ROWS_PER_PAGE - 1));
  assign in_ready    = (state == bmp2lcd_pkg::ST_IDLE);

  // shared address unit: display row of this step to a store byte address
  always_comb begin
    drow      = {page, step};
    srow      = bmp2lcd_pkg::SROW_W'(bmp2lcd_pkg::IMAGE_HEIGHT - 1 - int'(drow));
    addr_full = bmp2lcd_pkg::FULL_ADDR_W'(int'(srow) * bmp2lcd_pkg::ROW_BYTES
                + int'(column[bmp2lcd_pkg::COL_W-1:3]));
    pix_ok    = (int'(drow) < bmp2lcd_pkg::IMAGE_HEIGHT)
             && (int'(column) < bmp2lcd_pkg::IMAGE_WIDTH)
             && (int'(addr_full) < bmp2lcd_pkg::STORE_DEPTH);
    rd.en     = (state == bmp2lcd_pkg::ST_GATHER);
    rd.addr   = addr_full[bmp2lcd_pkg::ADDR_W-1:0];
  end

  // leftmost pixel sits in bit 7, so the bit index is the inverted column low bits
  always_comb begin
    pix     = issued_ok && !rd_data[~column[2:0]];
    acc_now = acc;
    if (issued_valid) begin
      acc_now[issued_x] = acc[issued_x] | pix;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bmp2lcd_pkg::ST_IDLE: begin
        if (accept_read) begin
          state_next = bmp2lcd_pkg::ST_GATHER;
        end
      end
      bmp2lcd_pkg::ST_GATHER: begin
        if (last_step) begin
          state_next = bmp2lcd_pkg::ST_FINISH;
        end
      end
      bmp2lcd_pkg::ST_FINISH: begin
        if (slot_free) begin
          state_next = bmp2lcd_pkg::ST_IDLE;
        end
      end
      default: state_next = bmp2lcd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bmp2lcd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step         <= '0;
      issued_valid <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (state == bmp2lcd_pkg::ST_FINISH && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        bmp2lcd_pkg::ST_IDLE: begin
          step         <= '0;
          issued_valid <= 1'b0;
        end
        bmp2lcd_pkg::ST_GATHER: begin
          step         <= step + 1'b1;
          issued_valid <= 1'b1;
        end
        bmp2lcd_pkg::ST_FINISH: begin
        end
        default: begin
          step <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept_read) begin
      page   <= in_page;
      column <= in_column;
      acc    <= '0;
    end else if (state == bmp2lcd_pkg::ST_GATHER) begin
      acc <= acc_now;
    end
    if (state == bmp2lcd_pkg::ST_GATHER) begin
      issued_x  <= step;
      issued_ok <= pix_ok;
    end
    if (state == bmp2lcd_pkg::ST_FINISH && slot_free) begin
      out_byte <= acc_now;
    end
  end

endmodule

// ----- hdl/bmp2lcd_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bmp2lcd_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic                                s_axis_tuser,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [bmp2lcd_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic read_taken;
  logic out_stalled;

  assign read_taken  = s_axis_tvalid && s_axis_tready
                    && (s_axis_tuser == bmp2lcd_pkg::REQ_READ);
  assign out_stalled = m_axis_tvalid && !m_axis_tready;

  // a stalled result keeps its value
  `CHK_ASSERT(a_out_hold, out_stalled |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // a read keeps the input side closed through its eight store reads and the finish step
  `CHK_ASSERT(a_read_busy, read_taken |=> !s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready, "request taken during a read")

  // a new result only comes out of the finish step of a read
  `CHK_IMPLY(a_out_from_read, $rose(m_axis_tvalid), $past(!s_axis_tready), "result without a read")

  // a read that was just taken gives no result yet
  `CHK_IMPLY(a_no_early_out, $past(read_taken), !$rose(m_axis_tvalid), "result too early")

endmodule

bind bitmap_to_lcd_page_converter_top bmp2lcd_checker u_bmp2lcd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  logic                                clk;
  logic                                rst;
  logic                                s_axis_tvalid;
  logic                                s_axis_tready;
  // load_offset[9:0], pixel_byte[17:10], page_index[20:18], column_index[27:21], zero[31:28]
  logic [bmp2lcd_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
  // req_type[0]
  logic                                s_axis_tuser;
  logic                                m_axis_tvalid;
  logic                                m_axis_tready;
  // page_byte[7:0]
  logic [bmp2lcd_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  logic [7:0] bitmap_bytes [bmp2lcd_pkg::STORE_DEPTH];
  bit         byte_loaded  [bmp2lcd_pkg::STORE_DEPTH];
  logic [7:0] expected_page_bytes [$];
  int         error_count;
  int         items_sent;
  int         burst_left;
  int         quiet_left;

  bitmap_to_lcd_page_converter_top uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // store address of row x of a page band at one byte column
  function automatic int band_addr(input int page, input int bcol, input int x);
    return (bmp2lcd_pkg::IMAGE_HEIGHT - 1 - (page * bmp2lcd_pkg::ROWS_PER_PAGE + x))
           * bmp2lcd_pkg::ROW_BYTES + bcol;
  endfunction

  function automatic logic [7:0] lcd_page_byte(input logic [2:0] page, input logic [6:0] col);
    logic [7:0] result;
    int         drow;
    int         addr;
    result = '0;
    for (int x = 0; x < bmp2lcd_pkg::ROWS_PER_PAGE; x++) begin
      drow = int'(page) * bmp2lcd_pkg::ROWS_PER_PAGE + x;
      if (drow < bmp2lcd_pkg::IMAGE_HEIGHT && int'(col) < bmp2lcd_pkg::IMAGE_WIDTH) begin
        addr = (bmp2lcd_pkg::IMAGE_HEIGHT - 1 - drow) * bmp2lcd_pkg::ROW_BYTES
               + int'(col >> 3);
        if (addr < bmp2lcd_pkg::STORE_DEPTH)
          result[x] = ~bitmap_bytes[addr][7 - col[2:0]];
      end
    end
    return result;
  endfunction

  function automatic bit band_ready(input int page, input int bcol);
    for (int x = 0; x < bmp2lcd_pkg::ROWS_PER_PAGE; x++)
      if (!byte_loaded[band_addr(page, bcol, x)]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic send_request(input bmp2lcd_pkg::req_kind_t kind, input logic [9:0] offset,
                              input logic [7:0] pixel, input logic [2:0] page,
                              input logic [6:0] col);
    int                                 gap;
    logic [bmp2lcd_pkg::IN_TDATA_W-1:0] tdata;
    if (burst_left == 0) begin
      if (quiet_left == 0 && $urandom_range(0, 9) == 0)
        quiet_left = $urandom_range(30, 120);
      gap = (quiet_left > 0) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    tdata = '0;
    tdata[bmp2lcd_pkg::OFFSET_LSB +: bmp2lcd_pkg::OFFSET_W] = offset;
    tdata[bmp2lcd_pkg::PIXEL_LSB +: bmp2lcd_pkg::PIXEL_W]   = pixel;
    tdata[bmp2lcd_pkg::PAGE_LSB +: bmp2lcd_pkg::PAGE_W]     = page;
    tdata[bmp2lcd_pkg::COL_LSB +: bmp2lcd_pkg::COL_W]       = col;
    @(negedge clk);
    s_axis_tdata  <= tdata;
    s_axis_tuser  <= kind;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    burst_left--;
    if (quiet_left > 0) quiet_left--;
    items_sent++;
    if (kind == bmp2lcd_pkg::REQ_LOAD) begin
      bitmap_bytes[offset] = pixel;
      byte_loaded[offset]  = 1'b1;
    end else begin
      expected_page_bytes.push_back(lcd_page_byte(page, col));
    end
  endtask

  task automatic send_load(input int offset, input logic [7:0] pixel);
    send_request(bmp2lcd_pkg::REQ_LOAD, offset[9:0], pixel, 3'($urandom), 7'($urandom));
  endtask

  task automatic send_read(input int page, input int col);
    send_request(bmp2lcd_pkg::REQ_READ, 10'($urandom), 8'($urandom), page[2:0], col[6:0]);
  endtask

  function automatic logic [7:0] random_pixels();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // fill the eight stored rows behind one page band, rows in rotated order when not patterned
  task automatic load_band(input int page, input int bcol, input bit patterned);
    logic [7:0] pattern [8];
    int         first;
    int         x;
    pattern = '{8'hFF, 8'h00, 8'h80, 8'h01, 8'h55, 8'hAA, 8'hFF, 8'h00};
    first = patterned ? 0 : $urandom_range(0, 7);
    for (int i = 0; i < bmp2lcd_pkg::ROWS_PER_PAGE; i++) begin
      x = (first + i) % bmp2lcd_pkg::ROWS_PER_PAGE;
      send_load(band_addr(page, bcol, x), patterned ? pattern[x] : random_pixels());
    end
  endtask

  task automatic wait_results_drained();
    while (expected_page_bytes.size() != 0) @(posedge clk);
  endtask

  // random read from any fully loaded band, if one turns up
  task automatic read_loaded_band();
    int page;
    int bcol;
    for (int tries = 0; tries < 8; tries++) begin
      page = $urandom_range(0, 7);
      bcol = $urandom_range(0, 15);
      if (band_ready(page, bcol)) begin
        send_read(page, bcol * 8 + $urandom_range(0, 7));
        return;
      end
    end
  endtask

  task automatic test_corner_cases();
    load_band(0, 0, 1'b1);
    load_band(7, 15, 1'b1);
    send_read(0, 0);
    send_read(0, 7);
    send_read(7, 120);
    send_read(7, 127);
    send_load(0, 8'hFF);
    send_load(1023, 8'h00);
  endtask

  task automatic test_random_traffic(input int item_goal);
    int page;
    int bcol;
    int stop_at;
    stop_at = items_sent + item_goal;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7: begin
          page = $urandom_range(0, 7);
          bcol = $urandom_range(0, 15);
          load_band(page, bcol, 1'b0);
          repeat ($urandom_range(1, 4)) send_read(page, bcol * 8 + $urandom_range(0, 7));
        end
        8, 9, 10, 11, 12, 13, 14: read_loaded_band();
        default: send_load($urandom_range(0, bmp2lcd_pkg::STORE_DEPTH - 1), random_pixels());
      endcase
    end
  endtask

  task automatic test_drain_pause();
    repeat (6) read_loaded_band();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    wait_results_drained();
    repeat (12) @(posedge clk);
    repeat (6) read_loaded_band();
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_page_bytes.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %02h", $time, m_axis_tdata);
        error_count++;
      end else begin
        if (m_axis_tdata !== expected_page_bytes[0]) begin
          $display("%0t: page_byte mismatch, expected %02h, actual %02h",
                   $time, expected_page_bytes[0], m_axis_tdata);
          error_count++;
        end
        void'(expected_page_bytes.pop_front());
      end
    end
  end

  // receiver backpressure, changing its mood every so often
  initial begin
    int stall_mode;
    m_axis_tready = 1'b0;
    forever begin
      stall_mode = $urandom_range(0, 3);
      repeat ($urandom_range(20, 200)) begin
        @(negedge clk);
        case (stall_mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          2:       m_axis_tready <= ($urandom_range(0, 7) != 0);
          default: m_axis_tready <= ($urandom_range(0, 15) == 0);
        endcase
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    error_count   = 0;
    items_sent    = 0;
    burst_left    = 0;
    quiet_left    = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_corner_cases();
    test_random_traffic(500);
    test_drain_pause();
    test_random_traffic(520);

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    wait_results_drained();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
